// ===== design/tdwq_pkg.sv =====
// ----------------------------------------------------------------------------
// tdwq_pkg
// Shared types and constants of the tick deadline wakeup queue.
// ----------------------------------------------------------------------------
package tdwq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 10;

  localparam int TICK_W = 32;
  localparam int TPS_W  = 10;
  localparam int ID_W   = 10;
  localparam int SEC_W  = 16;
  localparam int PROD_W = SEC_W - 1 + TPS_W;

  localparam logic [TPS_W-1:0] TPS_RESET = 10'd10;

  typedef enum logic {
    CMD_SLEEP = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_SLEEP_ACK = 1'b0,
    KIND_WOKEN     = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_ARG = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

endpackage

// ===== design/tdwq_intf.sv =====
// ----------------------------------------------------------------------------
// tdwq_intf
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tdwq_in_if;
  logic                             valid;
  logic                             ready;
  tdwq_pkg::cmd_e                   cmd;
  logic [tdwq_pkg::ID_W-1:0]        proc_id;
  logic signed [tdwq_pkg::SEC_W-1:0] sleep_seconds;

  modport source (output valid, cmd, proc_id, sleep_seconds, input ready);
  modport sink   (input valid, cmd, proc_id, sleep_seconds, output ready);
endinterface

interface tdwq_out_if;
  logic                      valid;
  logic                      ready;
  tdwq_pkg::kind_e           kind;
  tdwq_pkg::status_e         status;
  logic [tdwq_pkg::ID_W-1:0] woken_id;
  logic                      last;

  modport source (output valid, kind, status, woken_id, last, input ready);
  modport sink   (input valid, kind, status, woken_id, last, output ready);
endinterface

// ===== design/tdwq_ram.sv =====
// ----------------------------------------------------------------------------
// tdwq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tdwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/tick_deadline_wakeup_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tick_deadline_wakeup_queue_unit
// Tick counter and wake-up queue sorted by deadline, kept in a ring in RAM.
// ----------------------------------------------------------------------------
// Sleep item: the answer passes the multiply, add, compare, put and response
//   states, one compare step per entry compared; rejected ones skip to response.
// Tick item: woken ids come from the check state, one per cycle while not stalled.
// The next item is taken in the cycle after the last result is loaded (a tick
//   that wakes nothing gives no result and returns to idle, via check if not empty).
// Reset clears counter, fill count and head, sets the rate to 10; RAM is kept.
module tick_deadline_wakeup_queue_unit #(
  parameter int QUEUE_DEPTH = tdwq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = tdwq_pkg::ID_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tdwq_pkg::TPS_W-1:0] cfg_wdata_i,
  tdwq_in_if.sink                    in_i,
  tdwq_out_if.source                 out_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = tdwq_pkg::TICK_W;
  localparam int PW = tdwq_pkg::PROD_W;
  localparam int EW = TW + ID_BITS;
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ADD  = 7'b0000100,
    ST_CMP  = 7'b0001000,
    ST_PUT  = 7'b0010000,
    ST_RESP = 7'b0100000,
    ST_TCHK = 7'b1000000
  } state_e;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  state_e                     state_q, state_d;
  logic [TW-1:0]              tick_q, tick_d;
  logic [tdwq_pkg::TPS_W-1:0] tps_q;
  logic [CW-1:0]              count_q, count_d;
  logic [AW-1:0]              head_q, head_d;
  logic [AW-1:0]              j_q, j_d;
  logic [ID_BITS-1:0]         id_q, id_d;
  logic [tdwq_pkg::SEC_W-2:0] sec_q, sec_d;
  logic [PW-1:0]              prod_q, prod_d;
  logic [TW-1:0]              wake_q, wake_d;
  tdwq_pkg::status_e          status_q, status_d;
  logic                       pend_q, pend_d;
  logic [ID_BITS-1:0]         pend_id_q, pend_id_d;

  logic                       out_valid_q, out_valid_d;
  tdwq_pkg::kind_e            out_kind_q, out_kind_d;
  tdwq_pkg::status_e          out_status_q, out_status_d;
  logic [tdwq_pkg::ID_W-1:0]  out_id_q, out_id_d;
  logic                       out_last_q, out_last_d;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [EW-1:0]              ram_wdata, ram_rdata;
  logic [TW-1:0]              rd_wake;
  logic [ID_BITS-1:0]         rd_id;
  logic [TW:0]                wake_sum;
  logic                       out_free, due, pop, ins_we;

  tdwq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_wake  = ram_rdata[ID_BITS +: TW];
  assign rd_id    = ram_rdata[ID_BITS-1:0];
  assign out_free = !out_valid_q || out_o.ready;
  assign due      = (count_q != '0) && (rd_wake <= tick_q);
  assign wake_sum = {1'b0, tick_q} + (TW + 1)'(prod_q);
  assign ins_we   = (state_q == ST_PUT);
  assign pop      = (state_q == ST_TCHK) && !(pend_q && !out_free) && due;

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.status   = out_status_q;
  assign out_o.woken_id = out_id_q;
  assign out_o.last     = out_last_q;

  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    count_d      = count_q;
    head_d       = head_q;
    j_d          = j_q;
    id_d         = id_q;
    sec_d        = sec_q;
    prod_d       = prod_q;
    wake_d       = wake_q;
    status_d     = status_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_kind_d   = out_kind_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.cmd == tdwq_pkg::CMD_SLEEP) begin
            id_d = ID_BITS'(in_i.proc_id);
            if (in_i.sleep_seconds[tdwq_pkg::SEC_W-1]) begin
              status_d = tdwq_pkg::STAT_BAD_ARG;
              state_d  = ST_RESP;
            end else if (count_q == CW'(QUEUE_DEPTH)) begin
              status_d = tdwq_pkg::STAT_FULL;
              state_d  = ST_RESP;
            end else begin
              sec_d   = in_i.sleep_seconds[tdwq_pkg::SEC_W-2:0];
              state_d = ST_MUL;
            end
          end else begin
            if (tick_q != '1) begin
              tick_d = tick_q + TW'(1);
            end
            pend_d = 1'b0;
            if (count_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              state_d   = ST_TCHK;
            end
          end
        end
      end
      ST_MUL: begin
        prod_d  = PW'(sec_q) * PW'(tps_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        wake_d = wake_sum[TW] ? '1 : wake_sum[TW-1:0];
        j_d    = count_q[AW-1:0];
        if (count_q == '0) begin
          state_d = ST_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ring_add(head_q, count_q[AW-1:0] - AW'(1));
          state_d   = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rd_wake >= wake_q) begin
          // move entry one slot toward the tail
          ram_we    = 1'b1;
          ram_waddr = ring_add(head_q, j_q);
          ram_wdata = ram_rdata;
          j_d       = j_q - AW'(1);
          if (j_q == AW'(1)) begin
            state_d = ST_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ring_add(head_q, j_q - AW'(2));
          end
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = ring_add(head_q, j_q);
        ram_wdata = {wake_q, id_q};
        count_d   = count_q + CW'(1);
        status_d  = tdwq_pkg::STAT_OK;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = tdwq_pkg::KIND_SLEEP_ACK;
          out_status_d = status_q;
          out_id_d     = '0;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_TCHK: begin
        // pending id goes out once the next entry tells whether it is last
        if (!(pend_q && !out_free)) begin
          if (pend_q) begin
            out_valid_d  = 1'b1;
            out_kind_d   = tdwq_pkg::KIND_WOKEN;
            out_status_d = tdwq_pkg::STAT_OK;
            out_id_d     = tdwq_pkg::ID_W'(pend_id_q);
            out_last_d   = !due;
          end
          if (due) begin
            pend_d    = 1'b1;
            pend_id_d = rd_id;
            head_d    = ring_add(head_q, AW'(1));
            count_d   = count_q - CW'(1);
            ram_re    = 1'b1;
            ram_raddr = ring_add(head_q, AW'(1));
          end else begin
            pend_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      tps_q       <= tdwq_pkg::TPS_RESET;
      count_q     <= '0;
      head_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      count_q     <= count_d;
      head_q      <= head_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q          <= j_d;
    id_q         <= id_d;
    sec_q        <= sec_d;
    prod_q       <= prod_d;
    wake_q       <= wake_d;
    status_q     <= status_d;
    pend_id_q    <= pend_id_d;
    out_kind_q   <= out_kind_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_last_q   <= out_last_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> count_q != '0)
    else $error("pop from empty queue");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_we |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow fill count");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> ram_waddr != ram_raddr)
    else $error("RAM read and write to same entry");

  a_woken_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == tdwq_pkg::KIND_WOKEN) |->
      out_status_q == tdwq_pkg::STAT_OK)
    else $error("woken item with non-ok status");

endmodule
